>>> rtl/core/cabac_pkg.sv
// Package: shared types, constants and tables for the CABAC arithmetic decoder.
package cabac_pkg;

   localparam int NumContexts = 1024;
   localparam int CtxAddrWidth = 10;
   localparam int StateWidth = 7;
   localparam logic [8:0] RangeStart = 9'd510;
   localparam logic [5:0] QpMax = 6'd51;
   localparam logic [5:0] QpReset = 6'd26;

   typedef enum logic [2:0] {
      OP_INIT      = 3'd0,
      OP_START     = 3'd1,
      OP_DECISION  = 3'd2,
      OP_BYPASS    = 3'd3,
      OP_TERMINATE = 3'd4
   } op_type;

   // Front-to-back queue entry.
   typedef struct packed {
      logic [2:0]  operation;
      logic        ctx_valid;
      logic [CtxAddrWidth-1:0] ctx_index;
      logic [StateWidth-1:0] init_state;
      logic [8:0]  stream_bits;
   } cmd_type;

   function automatic logic [7:0] lps_range(input logic [5:0] s, input logic [1:0] q);
      logic [31:0] row;
      begin
         unique case (s)
            6'd0:  row = {8'd240,8'd208,8'd176,8'd128};
            6'd1:  row = {8'd227,8'd197,8'd167,8'd128};
            6'd2:  row = {8'd216,8'd187,8'd158,8'd128};
            6'd3:  row = {8'd205,8'd178,8'd150,8'd123};
            6'd4:  row = {8'd195,8'd169,8'd142,8'd116};
            6'd5:  row = {8'd185,8'd160,8'd135,8'd111};
            6'd6:  row = {8'd175,8'd152,8'd128,8'd105};
            6'd7:  row = {8'd166,8'd144,8'd122,8'd100};
            6'd8:  row = {8'd158,8'd137,8'd116,8'd95};
            6'd9:  row = {8'd150,8'd130,8'd110,8'd90};
            6'd10: row = {8'd142,8'd123,8'd104,8'd85};
            6'd11: row = {8'd135,8'd117,8'd99,8'd81};
            6'd12: row = {8'd128,8'd111,8'd94,8'd77};
            6'd13: row = {8'd122,8'd105,8'd89,8'd73};
            6'd14: row = {8'd116,8'd100,8'd85,8'd69};
            6'd15: row = {8'd110,8'd95,8'd80,8'd66};
            6'd16: row = {8'd104,8'd90,8'd76,8'd62};
            6'd17: row = {8'd99,8'd86,8'd72,8'd59};
            6'd18: row = {8'd94,8'd81,8'd69,8'd56};
            6'd19: row = {8'd89,8'd77,8'd65,8'd53};
            6'd20: row = {8'd85,8'd73,8'd62,8'd51};
            6'd21: row = {8'd80,8'd69,8'd59,8'd48};
            6'd22: row = {8'd76,8'd66,8'd56,8'd46};
            6'd23: row = {8'd72,8'd63,8'd53,8'd43};
            6'd24: row = {8'd69,8'd59,8'd50,8'd41};
            6'd25: row = {8'd65,8'd56,8'd48,8'd39};
            6'd26: row = {8'd62,8'd54,8'd45,8'd37};
            6'd27: row = {8'd59,8'd51,8'd43,8'd35};
            6'd28: row = {8'd56,8'd48,8'd41,8'd33};
            6'd29: row = {8'd53,8'd46,8'd39,8'd32};
            6'd30: row = {8'd50,8'd43,8'd37,8'd30};
            6'd31: row = {8'd48,8'd41,8'd35,8'd29};
            6'd32: row = {8'd45,8'd39,8'd33,8'd27};
            6'd33: row = {8'd43,8'd37,8'd31,8'd26};
            6'd34: row = {8'd41,8'd35,8'd30,8'd24};
            6'd35: row = {8'd39,8'd33,8'd28,8'd23};
            6'd36: row = {8'd37,8'd32,8'd27,8'd22};
            6'd37: row = {8'd35,8'd30,8'd26,8'd21};
            6'd38: row = {8'd33,8'd29,8'd24,8'd20};
            6'd39: row = {8'd31,8'd27,8'd23,8'd19};
            6'd40: row = {8'd30,8'd26,8'd22,8'd18};
            6'd41: row = {8'd28,8'd25,8'd21,8'd17};
            6'd42: row = {8'd27,8'd23,8'd20,8'd16};
            6'd43: row = {8'd25,8'd22,8'd19,8'd15};
            6'd44: row = {8'd24,8'd21,8'd18,8'd14};
            6'd45: row = {8'd23,8'd20,8'd17,8'd14};
            6'd46: row = {8'd22,8'd19,8'd16,8'd13};
            6'd47: row = {8'd21,8'd18,8'd15,8'd12};
            6'd48: row = {8'd20,8'd17,8'd14,8'd12};
            6'd49: row = {8'd19,8'd16,8'd14,8'd11};
            6'd50: row = {8'd18,8'd15,8'd13,8'd11};
            6'd51: row = {8'd17,8'd15,8'd12,8'd10};
            6'd52: row = {8'd16,8'd14,8'd12,8'd10};
            6'd53: row = {8'd15,8'd13,8'd11,8'd9};
            6'd54: row = {8'd14,8'd12,8'd11,8'd9};
            6'd55: row = {8'd14,8'd12,8'd10,8'd8};
            6'd56: row = {8'd13,8'd11,8'd9,8'd8};
            6'd57: row = {8'd12,8'd11,8'd9,8'd7};
            6'd58: row = {8'd12,8'd10,8'd9,8'd7};
            6'd59: row = {8'd11,8'd10,8'd8,8'd7};
            6'd60: row = {8'd11,8'd9,8'd8,8'd6};
            6'd61: row = {8'd10,8'd9,8'd7,8'd6};
            6'd62: row = {8'd9,8'd8,8'd7,8'd6};
            default: row = {8'd2,8'd2,8'd2,8'd2};
         endcase
         return row[q*8 +: 8];
      end
   endfunction

   function automatic logic [5:0] next_on_lps(input logic [5:0] s);
      logic [383:0] tbl;
      begin
         tbl = {6'd63,6'd38,6'd38,6'd37,6'd37,6'd37,6'd36,6'd36,
                6'd36,6'd35,6'd35,6'd35,6'd34,6'd34,6'd33,6'd33,
                6'd33,6'd32,6'd32,6'd31,6'd30,6'd30,6'd30,6'd29,
                6'd29,6'd28,6'd27,6'd27,6'd26,6'd26,6'd25,6'd24,
                6'd24,6'd23,6'd22,6'd22,6'd21,6'd21,6'd19,6'd19,
                6'd18,6'd18,6'd16,6'd16,6'd15,6'd15,6'd13,6'd13,
                6'd12,6'd11,6'd11,6'd9,6'd9,6'd8,6'd7,6'd6,
                6'd5,6'd4,6'd4,6'd2,6'd2,6'd1,6'd0,6'd0};
         return tbl[s*6 +: 6];
      end
   endfunction

endpackage

>>> rtl/core/cabac_arithmetic_decoder_unit.sv
// Top level of the CABAC binary arithmetic decoding engine.
// Usage:
//  - Input channel: present an operation with its fields and raise req_push;
//    a transaction completes on a clock edge with req_push high, req_full low.
//  - Result channel: while rsp_empty is low the oldest result (bin, bits
//    consumed) is on rsp_*; raising rsp_pop takes it.
//  - csr_write_enable/csr_write_data set slice QP (reset 26); write only
//    while the block is idle.
//  - The front end forms init states in a multiply register, then a
//    clip-and-map register; a four-entry queue decouples it from the engine.
//  - The engine registers the context memory read in stage A and decodes
//    in stage B, with a single leading-zero shift for renormalization.
//  - Throughput is one transaction per cycle while the receiver does not
//    stall, set by the range/offset loop.
//  - Reset clears range to 510, offset to 0 and all pipeline valids;
//    context memory is not cleared and must be initialized before use.
//  - When the receiver stalls the result register holds, the queue fills
//    and req_full rises; nothing is dropped.
module cabac_arithmetic_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [2:0]        req_operation,
   input  logic [9:0]        req_context_index,
   input  logic signed [7:0] req_init_slope,
   input  logic signed [7:0] req_init_offset,
   input  logic [8:0]        req_stream_bits,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_bin_value,
   output logic [3:0]        rsp_bits_consumed,
   input  logic              csr_write_enable,
   input  logic [5:0]        csr_write_data
);
   logic [5:0] qp_ff;
   logic f_valid, f_ready, q_valid, q_ready;
   cabac_pkg::cmd_type f_cmd, q_cmd;

   always_ff @(posedge clock) begin
      if (reset) qp_ff <= cabac_pkg::QpReset;
      else if (csr_write_enable) qp_ff <= csr_write_data;
   end

   cabac_front u_front (
      .clock, .reset, .req_push, .req_full, .req_operation, .req_context_index,
      .req_init_slope, .req_init_offset, .req_stream_bits, .qp(qp_ff),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   cabac_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   cabac_engine u_engine (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_empty, .rsp_pop, .rsp_bin_value, .rsp_bits_consumed
   );
endmodule

>>> rtl/core/cabac_front.sv
// Front end: accepts operations, computes context init state, registers a command.
module cabac_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [2:0]          req_operation,
   input  logic [9:0]          req_context_index,
   input  logic signed [7:0]   req_init_slope,
   input  logic signed [7:0]   req_init_offset,
   input  logic [8:0]          req_stream_bits,
   input  logic [5:0]          qp,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output cabac_pkg::cmd_type  cmd
);
   // Stage 1: register the product; stage 2: clip and map to a state.
   logic               s1_valid_ff, s1_valid_in;
   logic signed [14:0] s1_prod_ff;
   logic signed [7:0]  s1_n_ff;
   cabac_pkg::cmd_type s1_cmd_ff;
   logic               s2_valid_ff;
   cabac_pkg::cmd_type s2_cmd_ff, s2_cmd_in;
   logic               adv2, adv1;
   logic [5:0]         qpc;
   logic signed [10:0] scaled, pre;
   logic [6:0]         prec;

   assign adv2 = !s2_valid_ff || cmd_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_full = !adv1;
   assign s1_valid_in = adv1 ? req_push : s1_valid_ff;
   assign qpc = (qp > cabac_pkg::QpMax) ? cabac_pkg::QpMax : qp;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (adv2) s2_valid_ff <= s1_valid_ff;
      end
      if (adv1) begin
         s1_prod_ff <= 15'(req_init_slope) * 15'($signed({1'b0, qpc}));
         s1_n_ff <= req_init_offset;
         s1_cmd_ff.operation <= req_operation;
         s1_cmd_ff.ctx_valid <= 32'(req_context_index) < cabac_pkg::NumContexts;
         s1_cmd_ff.ctx_index <= req_context_index;
         s1_cmd_ff.init_state <= '0;
         s1_cmd_ff.stream_bits <= req_stream_bits;
      end
      if (adv2) s2_cmd_ff <= s2_cmd_in;
   end

   always_comb begin
      // Arithmetic shift floors, matching floor(m*qp/16).
      scaled = 11'(s1_prod_ff >>> 4);
      pre = scaled + 11'(s1_n_ff);
      if (pre < 11'sd1) prec = 7'd1;
      else if (pre > 11'sd126) prec = 7'd126;
      else prec = pre[6:0];
      s2_cmd_in = s1_cmd_ff;
      if (prec <= 7'd63) s2_cmd_in.init_state = {6'(7'd63 - prec), 1'b0};
      else s2_cmd_in.init_state = {6'(prec - 7'd64), 1'b1};
   end

   assign cmd_valid = s2_valid_ff;
   assign cmd = s2_cmd_ff;
endmodule

>>> rtl/core/cabac_queue.sv
// Short command queue between front end and engine.
module cabac_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cabac_pkg::cmd_type in_cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output cabac_pkg::cmd_type out_cmd
);
   cabac_pkg::cmd_type mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       do_wr, do_rd;

   assign in_ready = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign do_wr = in_valid && in_ready;
   assign do_rd = out_valid && out_ready;
   assign out_cmd = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_wr) wr_ff <= wr_ff + 2'd1;
         if (do_rd) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(do_wr) - 3'(do_rd);
      end
      if (do_wr) mem_ff[wr_ff] <= in_cmd;
   end
endmodule

>>> rtl/core/cabac_engine.sv
// Back end: context memory, arithmetic engine and result register.
module cabac_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  cabac_pkg::cmd_type cmd,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_bin_value,
   output logic [3:0]         rsp_bits_consumed
);
   // Stage A reads the context memory; stage B runs the engine and writes back.
   logic [cabac_pkg::StateWidth-1:0] ctx_mem [cabac_pkg::NumContexts];
   logic               a_valid_ff;
   cabac_pkg::cmd_type a_cmd_ff;
   logic [6:0]         rd_data_ff;
   logic               fwd_ff;
   logic [6:0]         fwd_data_ff;
   logic               b_go, adv_a;
   logic               out_valid_ff;
   logic               out_bin_ff;
   logic [3:0]         out_used_ff;
   logic [8:0]         range_ff, range_in, offset_ff, offset_in;
   logic               wr_en;
   logic [6:0]         wr_data;
   logic               bin;
   logic [3:0]         used;
   logic [6:0]         st;
   logic [5:0]         s;
   logic [7:0]         lps;
   logic [8:0]         rmps, r, o;
   logic [9:0]         v;
   logic [3:0]         nz;
   logic [17:0]        cat;

   assign b_go = a_valid_ff && (!out_valid_ff || rsp_pop);
   assign adv_a = !a_valid_ff || b_go;
   assign cmd_ready = adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         range_ff <= cabac_pkg::RangeStart;
         offset_ff <= '0;
      end else begin
         if (adv_a) a_valid_ff <= cmd_valid;
         if (b_go) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
         if (b_go) begin
            range_ff <= range_in;
            offset_ff <= offset_in;
         end
      end
      if (adv_a) begin
         a_cmd_ff <= cmd;
         rd_data_ff <= ctx_mem[cmd.ctx_index];
         // Bypass the memory when the entry in B is written this cycle.
         fwd_ff <= b_go && wr_en && cmd.ctx_index == a_cmd_ff.ctx_index;
         fwd_data_ff <= wr_data;
      end else if (b_go && wr_en) begin
         fwd_ff <= 1'b1;
         fwd_data_ff <= wr_data;
      end
      if (b_go && wr_en) ctx_mem[a_cmd_ff.ctx_index] <= wr_data;
      if (b_go) begin
         out_bin_ff <= bin;
         out_used_ff <= used;
      end
   end

   // Leading-zero count of a 9-bit value, capped at 9.
   function automatic logic [3:0] lzc9(input logic [8:0] x);
      logic [3:0] n;
      begin
         n = 4'd9;
         for (int i = 0; i < 9; i++) if (x[i]) n = 4'(8 - i);
         return n;
      end
   endfunction

   always_comb begin
      st = a_cmd_ff.ctx_valid ? (fwd_ff ? fwd_data_ff : rd_data_ff) : 7'd0;
      s = st[6:1];
      lps = cabac_pkg::lps_range(s, range_ff[7:6]);
      rmps = range_ff - {1'b0, lps};
      bin = 1'b0;
      used = 4'd0;
      wr_en = 1'b0;
      wr_data = a_cmd_ff.init_state;
      r = range_ff;
      o = offset_ff;
      v = '0;
      nz = 4'd0;
      cat = '0;
      range_in = range_ff;
      offset_in = offset_ff;
      unique case (a_cmd_ff.operation)
         cabac_pkg::OP_INIT: wr_en = a_cmd_ff.ctx_valid;
         cabac_pkg::OP_START: begin
            range_in = cabac_pkg::RangeStart;
            offset_in = a_cmd_ff.stream_bits;
            used = 4'd9;
         end
         cabac_pkg::OP_DECISION: begin
            wr_en = a_cmd_ff.ctx_valid;
            if (offset_ff >= rmps) begin
               bin = !st[0];
               o = offset_ff - rmps;
               r = {1'b0, lps};
               wr_data = {cabac_pkg::next_on_lps(s), (s == 6'd0) ? !st[0] : st[0]};
            end else begin
               bin = st[0];
               r = rmps;
               wr_data = {(s < 6'd62) ? s + 6'd1 : s, st[0]};
            end
            nz = lzc9(r);
            cat = {o, a_cmd_ff.stream_bits} << nz;
            range_in = 9'(r << nz);
            offset_in = cat[17:9];
            used = nz;
         end
         cabac_pkg::OP_BYPASS: begin
            v = {offset_ff, a_cmd_ff.stream_bits[8]};
            if (v >= {1'b0, range_ff}) begin
               v = v - {1'b0, range_ff};
               bin = 1'b1;
            end
            offset_in = v[8:0];
            used = 4'd1;
         end
         cabac_pkg::OP_TERMINATE: begin
            r = range_ff - 9'd2;
            range_in = r;
            if (offset_ff >= r) begin
               bin = 1'b1;
            end else begin
               nz = lzc9(r);
               cat = {offset_ff, a_cmd_ff.stream_bits} << nz;
               range_in = 9'(r << nz);
               offset_in = cat[17:9];
               used = nz;
            end
         end
         default: ;
      endcase
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_bin_value = out_bin_ff;
   assign rsp_bits_consumed = out_used_ff;
endmodule

>>> tb/sv/tb.sv
// Testbench for the CABAC arithmetic decoder unit: random and directed bins vs. a predictor.
`timescale 1ns / 100ps
module tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [2:0] req_operation = '0;
   logic [9:0] req_context_index = '0;
   logic signed [7:0] req_init_slope = '0;
   logic signed [7:0] req_init_offset = '0;
   logic [8:0] req_stream_bits = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic rsp_bin_value;
   logic [3:0] rsp_bits_consumed;
   logic csr_write_enable = 1'b0;
   logic [5:0] csr_write_data = '0;

   cabac_arithmetic_decoder_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: our own copy of the engine and the context store.
   typedef struct packed {
      logic       bin;
      logic [3:0] used;
   } bin_result_type;

   logic [6:0] ctx_state [cabac_pkg::NumContexts];
   bit         ctx_written [cabac_pkg::NumContexts];
   logic [8:0] pred_range;
   logic [8:0] pred_offset;
   logic [5:0] pred_qp;
   bin_result_type expected_bins[$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   bit         sender_idle_ok = 1'b1;  // random idling enabled on input side
   bit         receiver_idle_ok = 1'b1;
   bit         receiver_hold = 1'b0;   // receiver refuses to pop
   event       hold_start;

   // Lookup tables, transcribed independently as arrays.
   byte unsigned lps_tab [64][4] = '{
      '{128,176,208,240},'{128,167,197,227},'{128,158,187,216},'{123,150,178,205},
      '{116,142,169,195},'{111,135,160,185},'{105,128,152,175},'{100,122,144,166},
      '{95,116,137,158},'{90,110,130,150},'{85,104,123,142},'{81,99,117,135},
      '{77,94,111,128},'{73,89,105,122},'{69,85,100,116},'{66,80,95,110},
      '{62,76,90,104},'{59,72,86,99},'{56,69,81,94},'{53,65,77,89},
      '{51,62,73,85},'{48,59,69,80},'{46,56,66,76},'{43,53,63,72},
      '{41,50,59,69},'{39,48,56,65},'{37,45,54,62},'{35,43,51,59},
      '{33,41,48,56},'{32,39,46,53},'{30,37,43,50},'{29,35,41,48},
      '{27,33,39,45},'{26,31,37,43},'{24,30,35,41},'{23,28,33,39},
      '{22,27,32,37},'{21,26,30,35},'{20,24,29,33},'{19,23,27,31},
      '{18,22,26,30},'{17,21,25,28},'{16,20,23,27},'{15,19,22,25},
      '{14,18,21,24},'{14,17,20,23},'{13,16,19,22},'{12,15,18,21},
      '{12,14,17,20},'{11,14,16,19},'{11,13,15,18},'{10,12,15,17},
      '{10,12,14,16},'{9,11,13,15},'{9,11,12,14},'{8,10,12,14},
      '{8,9,11,13},'{7,9,11,12},'{7,9,10,12},'{7,8,10,11},
      '{6,8,9,11},'{6,7,9,10},'{6,7,8,9},'{2,2,2,2}};
   byte unsigned lps_next_tab [64] = '{
      0,0,1,2,2,4,4,5,6,7,8,9,9,11,11,12,
      13,13,15,15,16,16,18,18,19,19,21,21,22,22,23,24,
      24,25,26,26,27,27,28,29,29,30,30,30,31,32,32,33,
      33,33,34,34,35,35,35,36,36,36,37,37,37,38,38,63};

   // Renormalize: shift range until bit 8 set, at most nine window bits.
   function automatic logic [3:0] renorm(input logic [8:0] window);
      logic [3:0] n;
      n = 0;
      while (pred_range < 9'd256 && n < 4'd9) begin
         pred_range = pred_range << 1;
         pred_offset = {pred_offset[7:0], window[8 - n]};
         n++;
      end
      return n;
   endfunction

   function automatic bin_result_type predict(input logic [2:0] op, input logic [9:0] idx,
                                            input logic signed [7:0] m,
                                            input logic signed [7:0] n,
                                            input logic [8:0] window);
      bin_result_type r;
      int prod, scaled, pre, qp;
      logic [5:0] s;
      logic mps;
      logic [8:0] lps;
      logic [9:0] v;
      r = '0;
      case (op)
         cabac_pkg::OP_INIT: begin
            qp = (pred_qp > cabac_pkg::QpMax) ? int'(cabac_pkg::QpMax) : int'(pred_qp);
            prod = int'(m) * qp;
            scaled = prod >= 0 ? prod / 16 : -((-prod + 15) / 16);
            pre = scaled + int'(n);
            if (pre < 1) pre = 1;
            if (pre > 126) pre = 126;
            if (pre <= 63) ctx_state[idx] = {6'(63 - pre), 1'b0};
            else ctx_state[idx] = {6'(pre - 64), 1'b1};
            ctx_written[idx] = 1'b1;
         end
         cabac_pkg::OP_START: begin
            pred_range = cabac_pkg::RangeStart;
            pred_offset = window;
            r.used = 4'd9;
         end
         cabac_pkg::OP_DECISION: begin
            s = ctx_state[idx][6:1];
            mps = ctx_state[idx][0];
            lps = 9'(lps_tab[s][pred_range[7:6]]);
            pred_range = pred_range - lps;
            if (pred_offset >= pred_range) begin
               r.bin = ~mps;
               pred_offset = pred_offset - pred_range;
               pred_range = lps;
               ctx_state[idx] = {6'(lps_next_tab[s]), (s == 6'd0) ? ~mps : mps};
            end else begin
               r.bin = mps;
               ctx_state[idx] = {(s < 6'd62) ? s + 6'd1 : s, mps};
            end
            r.used = renorm(window);
         end
         cabac_pkg::OP_BYPASS: begin
            v = {pred_offset, window[8]};
            if (v >= {1'b0, pred_range}) begin
               v = v - {1'b0, pred_range};
               r.bin = 1'b1;
            end
            pred_offset = v[8:0];
            r.used = 4'd1;
         end
         cabac_pkg::OP_TERMINATE: begin
            pred_range = pred_range - 9'd2;
            if (pred_offset >= pred_range) r.bin = 1'b1;
            else r.used = renorm(window);
         end
         default: ;
      endcase
      return r;
   endfunction

   // Send one transaction; waits for acceptance, then queues the prediction.
   task automatic send_op(input logic [2:0] op, input logic [9:0] idx,
                          input logic signed [7:0] m, input logic signed [7:0] n,
                          input logic [8:0] window);
      while (sender_idle_ok && $urandom_range(99) < 19) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_operation <= op;
      req_context_index <= idx;
      req_init_slope <= m;
      req_init_offset <= n;
      req_stream_bits <= window;
      do @(posedge clock); while (req_full);
      expected_bins.push_back(predict(op, idx, m, n, window));
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_qp(input logic [5:0] qp);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= qp;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pred_qp = qp;
   endtask

   // Pick a context that has been initialized.
   function automatic logic [9:0] written_ctx();
      logic [9:0] i;
      do i = 10'($urandom_range(cabac_pkg::NumContexts - 1)); while (!ctx_written[i]);
      return i;
   endfunction

   task automatic test_directed();
      send_op(cabac_pkg::OP_INIT, 10'd0, 8'sd127, 8'sd127, '0);
      send_op(cabac_pkg::OP_INIT, 10'd1023, -8'sd128, -8'sd128, '0);
      send_op(cabac_pkg::OP_INIT, 10'd5, 8'sd0, 8'sd64, '0);
      send_op(cabac_pkg::OP_INIT, 10'd6, 8'sd0, 8'sd63, '0);
      send_op(cabac_pkg::OP_START, 10'd0, '0, '0, 9'd0);
      send_op(cabac_pkg::OP_DECISION, 10'd0, '0, '0, 9'h1FF);
      send_op(cabac_pkg::OP_DECISION, 10'd1023, '0, '0, 9'h000);
      send_op(cabac_pkg::OP_BYPASS, 10'd0, '0, '0, 9'h100);
      send_op(cabac_pkg::OP_TERMINATE, 10'd0, '0, '0, 9'h0AA);
      send_op(cabac_pkg::OP_START, 10'd0, '0, '0, 9'h1FF);   // offset above range: corrupt state
      send_op(cabac_pkg::OP_DECISION, 10'd5, '0, '0, 9'h155);
      send_op(cabac_pkg::OP_TERMINATE, 10'd0, '0, '0, 9'h000);
      send_op(cabac_pkg::OP_START, 10'd0, '0, '0, 9'd1);
      repeat (6) send_op(cabac_pkg::OP_TERMINATE, 10'd0, '0, '0, 9'h000); // wear range down
      send_op(cabac_pkg::OP_DECISION, 10'd6, '0, '0, 9'h0F0);
      for (int op = 5; op < 8; op++) send_op(3'(op), 10'd7, 8'sd5, 8'sd5, 9'h1FF);
      send_op(cabac_pkg::OP_START, 10'd0, '0, '0, 9'd10);
   endtask

   task automatic test_qp_sweep();
      logic [5:0] qps [4] = '{6'd0, 6'd51, 6'd63, 6'd17};
      foreach (qps[q]) begin
         write_qp(qps[q]);
         for (int k = 0; k < 16; k++)
            send_op(cabac_pkg::OP_INIT, 10'($urandom_range(1023)), 8'($urandom),
                    8'($urandom), '0);
      end
   endtask

   // Random slices: mostly decision bins, with bypass bins, inits, starts, terminates and undefined operations.
   task automatic test_random(input int count);
      int sent;
      logic [2:0] op;
      sent = 0;
      while (sent < count) begin
         if (sent == count / 3) begin
            sender_idle_ok = 1'b0;  // long gap-free stretch
            receiver_idle_ok = 1'b0;
         end
         if (sent == count / 2) begin
            sender_idle_ok = 1'b1;
            receiver_idle_ok = 1'b1;
            -> hold_start;
         end
         case ($urandom_range(19))
            0: op = cabac_pkg::OP_START;
            1, 2: op = cabac_pkg::OP_INIT;
            3, 4, 5: op = cabac_pkg::OP_BYPASS;
            6: op = cabac_pkg::OP_TERMINATE;
            7: op = 3'($urandom_range(7, 5));
            default: op = cabac_pkg::OP_DECISION;
         endcase
         if (op == cabac_pkg::OP_DECISION)
            send_op(op, written_ctx(), 8'($urandom), 8'($urandom), 9'($urandom));
         else
            send_op(op, 10'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
         sent++;
      end
   endtask

   task automatic test_pause_and_requalify();
      drain();  // sender pauses until every result has come
      write_qp(6'd40);
      send_op(cabac_pkg::OP_START, 10'd0, '0, '0, 9'($urandom));
      test_random(300);
   endtask

   // Long receiver hold-off, counted here.
   initial forever begin
      @(hold_start);
      receiver_hold <= 1'b1;
      repeat (60) @(posedge clock);
      receiver_hold <= 1'b0;
   end

   // Result checker and receiver.
   always @(posedge clock) begin
      bin_result_type exp_r;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_bins.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transaction on rsp");
         end else begin
            exp_r = expected_bins.pop_front();
            if (rsp_bin_value !== exp_r.bin || rsp_bits_consumed !== exp_r.used) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: bin exp %0d got %0d, bits exp %0d got %0d",
                           exp_r.bin, rsp_bin_value, exp_r.used, rsp_bits_consumed);
            end
         end
      end
      if (receiver_hold) rsp_pop <= 1'b0;
      else rsp_pop <= !(receiver_idle_ok && $urandom_range(99) < 19);
   end

   always @(posedge clock) begin
      if (cycle_count > 200000) begin
         $display("cabac_arithmetic_decoder_unit test failed");
         $finish;
      end
   end

   initial begin
      pred_range = cabac_pkg::RangeStart;
      pred_offset = '0;
      pred_qp = cabac_pkg::QpReset;
      foreach (ctx_written[i]) ctx_written[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_qp_sweep();
      write_qp(6'd26);
      test_random(1060);
      test_pause_and_requalify();
      drain();
      if (mismatch_count == 0 && expected_bins.size() == 0)
         $display("cabac_arithmetic_decoder_unit test passed");
      else
         $display("cabac_arithmetic_decoder_unit test failed");
      $finish;
   end
endmodule
